>>> rtl/ip6t2b_pkg.sv
// Package with the types, constants and hex decoder for the IPv6 text-to-binary converter.
package ip6t2b_pkg;

  localparam int NUM_GROUPS = 8;
  localparam int GROUP_W    = 16;
  localparam int CHAR_W     = 8;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = 4;
  localparam int NIBBLE_W   = 4;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [GROUP_W-1:0] group_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] group_vec_t;

  typedef struct packed {
    logic                ok;
    logic [NIBBLE_W-1:0] val;
  } hex_t;

  localparam char_t COLON_CHAR = 8'h3A;
  localparam char_t DIGIT_0    = 8'h30;
  localparam char_t DIGIT_9    = 8'h39;
  localparam char_t LOWER_A    = 8'h61;
  localparam char_t LOWER_F    = 8'h66;
  localparam char_t UPPER_A    = 8'h41;
  localparam char_t UPPER_F    = 8'h46;
  localparam logic [NIBBLE_W-1:0] TEN = 4'd10;

  function automatic hex_t hex_digit(input char_t c);
    hex_t h;
    char_t d;
    h.ok  = 1'b0;
    h.val = '0;
    if (c >= DIGIT_0 && c <= DIGIT_9) begin
      d     = c - DIGIT_0;
      h.ok  = 1'b1;
      h.val = d[NIBBLE_W-1:0];
    end else if (c >= LOWER_A && c <= LOWER_F) begin
      d     = c - LOWER_A;
      h.ok  = 1'b1;
      h.val = d[NIBBLE_W-1:0] + TEN;
    end else if (c >= UPPER_A && c <= UPPER_F) begin
      d     = c - UPPER_A;
      h.ok  = 1'b1;
      h.val = d[NIBBLE_W-1:0] + TEN;
    end
    return h;
  endfunction

endpackage

>>> rtl/ip6t2b_if.sv
// Valid/ready channel interfaces for the character input and the address output.
interface ip6t2b_in_if;
  import ip6t2b_pkg::*;

  logic  valid;
  logic  ready;
  char_t ch;
  logic  last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink (input valid, input ch, input last_char, output ready);
endinterface

interface ip6t2b_out_if;
  import ip6t2b_pkg::*;

  logic  valid;
  logic  ready;
  word_t word0;
  word_t word1;
  word_t word2;
  word_t word3;

  modport source (output valid, output word0, output word1, output word2, output word3,
                  input ready);
  modport sink (input valid, input word0, input word1, input word2, input word3,
                output ready);
endinterface

>>> rtl/ipv6_text_to_binary_core.sv
// IPv6 text-to-binary converter: characters in, one 128-bit address out per string.
//
//   Channel   Direction  Transaction
//   in_chan   sink       one character (ch) and its end-of-string mark (last_char)
//   out_chan  source     one address as word0..word3, group 0 most significant
//
// Each character is folded into the group state as it is taken.
// The character with last_char set loads the aligned address into the output
// register, which shows it from the next cycle. A character is accepted in every
// cycle unless the output register still holds an address that is stalled.
// Synchronous reset clears the group state and the output valid flag.
module ipv6_text_to_binary_core (
  input  logic                 clk,
  input  logic                 rst_n,
  ip6t2b_in_if.sink            in_chan,
  ip6t2b_out_if.source         out_chan
);
  import ip6t2b_pkg::*;

  group_vec_t store_r, store_nxt, fstore, shifted, aligned;
  group_t     cur_r, cur_nxt;
  count_t     cnt_r, cnt_nxt, fcnt, gpos_r, gpos_nxt, tail_start, shift_groups;
  logic       gap_r, gap_nxt, prev_r, prev_nxt, stop_r, stop_nxt, gap_ok;
  hex_t       hv;
  logic       in_ready, in_acc;
  group_vec_t out_r;
  logic       out_valid_r;

  assign in_ready      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;

  always_comb begin
    store_nxt = store_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    gpos_nxt  = gpos_r;
    gap_nxt   = gap_r;
    prev_nxt  = prev_r;
    stop_nxt  = stop_r;
    hv        = hex_digit(in_chan.ch);

    if (in_chan.ch == COLON_CHAR) begin
      if (prev_r) begin
        if (!gap_r) begin
          gap_nxt  = 1'b1;
          gpos_nxt = cnt_r;
        end
      end else begin
        for (int i = 0; i < NUM_GROUPS; i++) begin
          if (cnt_r == CNT_W'(i)) begin
            store_nxt[i] = cur_r;
          end
        end
        if (cnt_r < CNT_W'(NUM_GROUPS)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        cur_nxt  = '0;
        stop_nxt = 1'b0;
      end
      prev_nxt = 1'b1;
    end else begin
      if (!hv.ok) begin
        stop_nxt = 1'b1;
      end else if (!stop_r) begin
        cur_nxt = {cur_r[GROUP_W-NIBBLE_W-1:0], hv.val};
      end
      prev_nxt = 1'b0;
    end

    // The group in progress is closed at the end unless the string ended on a colon.
    fstore = store_nxt;
    fcnt   = cnt_nxt;
    if (!prev_nxt) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        if (cnt_nxt == CNT_W'(i)) begin
          fstore[i] = cur_nxt;
        end
      end
      if (cnt_nxt < CNT_W'(NUM_GROUPS)) begin
        fcnt = cnt_nxt + 1'b1;
      end
    end

    // Groups after the gap move to the right end of the address.
    gap_ok       = gap_nxt && (gpos_nxt <= fcnt);
    shift_groups = CNT_W'(NUM_GROUPS) - fcnt;
    shifted      = fstore << (GROUP_W * shift_groups);
    tail_start   = shift_groups + gpos_nxt;
    for (int d = 0; d < NUM_GROUPS; d++) begin
      aligned[d] = '0;
      if (gap_ok) begin
        if (CNT_W'(d) < gpos_nxt) begin
          aligned[d] = fstore[d];
        end else if (CNT_W'(d) >= tail_start) begin
          aligned[d] = shifted[d];
        end
      end else if (CNT_W'(d) < fcnt) begin
        aligned[d] = fstore[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      cur_r   <= '0;
      cnt_r   <= '0;
      gpos_r  <= '0;
      gap_r   <= 1'b0;
      prev_r  <= 1'b0;
      stop_r  <= 1'b0;
    end else if (in_acc) begin
      if (in_chan.last_char) begin
        store_r <= '0;
        cur_r   <= '0;
        cnt_r   <= '0;
        gpos_r  <= '0;
        gap_r   <= 1'b0;
        prev_r  <= 1'b0;
        stop_r  <= 1'b0;
      end else begin
        store_r <= store_nxt;
        cur_r   <= cur_nxt;
        cnt_r   <= cnt_nxt;
        gpos_r  <= gpos_nxt;
        gap_r   <= gap_nxt;
        prev_r  <= prev_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_chan.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.last_char) begin
      out_r <= aligned;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.word0 = {out_r[0], out_r[1]};
  assign out_chan.word1 = {out_r[2], out_r[3]};
  assign out_chan.word2 = {out_r[4], out_r[5]};
  assign out_chan.word3 = {out_r[6], out_r[7]};

endmodule

>>> rtl/ip6t2b_check.sv
// Port-level assertions for the IPv6 text-to-binary converter and their bind.
module ip6t2b_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last_char,
  input logic               out_valid,
  input logic               out_ready,
  input ip6t2b_pkg::word_t  out_word0,
  input ip6t2b_pkg::word_t  out_word1,
  input ip6t2b_pkg::word_t  out_word2,
  input ip6t2b_pkg::word_t  out_word3
);
  import ip6t2b_pkg::*;

  logic last_acc;
  assign last_acc = in_valid && in_ready && in_last_char;

  // A stalled address stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word0) && $stable(out_word1)
      && $stable(out_word2) && $stable(out_word3))
    else $error("stalled output transaction changed");

  // An address appears only after the last character of a string was taken.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(last_acc) || $past(out_valid && !out_ready))
    else $error("output transaction without a final character");

  // An empty output register never blocks the input.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // Every final character yields an address in the next cycle.
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    last_acc |=> out_valid)
    else $error("final character did not produce an address");

endmodule

bind ipv6_text_to_binary_core ip6t2b_check u_ip6t2b_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_last_char (in_chan.last_char),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_word0    (out_chan.word0),
  .out_word1    (out_chan.word1),
  .out_word2    (out_chan.word2),
  .out_word3    (out_chan.word3)
);
